// File: design/cmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cmb_pkg;

	// Sample and delay line geometry
	localparam int SAMPLE_W    = 16;
	localparam int DELAY_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Shared multiplier: signed 18 x 18
	localparam int MUL_W  = 18;
	localparam int PROD_W = 2 * MUL_W;

	// Coefficient limits
	localparam logic [ADDR_W-1:0]          DELAY_MIN = ADDR_W'(1);
	localparam logic [ADDR_W-1:0]          DELAY_MAX = ADDR_W'(DELAY_DEPTH - 2);
	localparam logic signed [SAMPLE_W-1:0] FB_LIMIT  = 16'sd32440;
	localparam logic [CFG_DATA_W-1:0]      Q_ONE     = 16'd32768;

	// Saturation bounds on a 24-bit intermediate
	localparam logic signed [23:0] SAMPLE_MAX = 24'sd32767;
	localparam logic signed [23:0] SAMPLE_MIN = -24'sd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_LENGTH  = 3'd0,
		REG_COMB_MODE     = 3'd1,
		REG_FEEDBACK_GAIN = 3'd2,
		REG_DAMPING_COEF  = 3'd3,
		REG_WET_MIX       = 3'd4,
		REG_OUT_LEVEL     = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_FEEDFORWARD = 2'd0,
		MODE_FEEDBACK    = 2'd1,
		MODE_DAMPED      = 2'd2,
		MODE_PLAIN_DELAY = 2'd3
	} comb_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_LP,
		ST_FB2,
		ST_WB,
		ST_MIX,
		ST_BLEND,
		ST_LVL,
		ST_OUT
	} core_state_t;

	// Configuration as seen by the datapath, with delay, gain, damping and mix already clamped
	typedef struct packed {
		logic [ADDR_W-1:0]          delay_len;
		comb_mode_t                 mode;
		logic signed [SAMPLE_W-1:0] fb_gain;
		logic [CFG_DATA_W-1:0]      damp;
		logic [CFG_DATA_W-1:0]      mix;
		logic [CFG_DATA_W-1:0]      level;
	} cmb_cfg_t;

	// Q1.15 product back to sample scale, round half up
	function automatic logic signed [21:0] round_q15(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W:0] t;
		t = {p[PROD_W-1], p} + (PROD_W+1)'(16384);
		return t[PROD_W:15];
	endfunction

	// Q3.13 product back to sample scale, round half up
	function automatic logic signed [23:0] round_q13(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W:0] t;
		t = {p[PROD_W-1], p} + (PROD_W+1)'(4096);
		return t[PROD_W:13];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [23:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > SAMPLE_MAX) begin
			r = SAMPLE_MAX[SAMPLE_W-1:0];
		end else if (v < SAMPLE_MIN) begin
			r = SAMPLE_MIN[SAMPLE_W-1:0];
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/cmb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Delay line storage: one write port, one read port, registered read data
module cmb_ram
	import cmb_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [ADDR_W-1:0]          waddr,
	input  wire logic signed [SAMPLE_W-1:0] wdata,
	input  wire logic                       re,
	input  wire logic [ADDR_W-1:0]          raddr,
	output logic signed [SAMPLE_W-1:0]      rdata
);

	logic signed [SAMPLE_W-1:0] mem [DELAY_DEPTH];
	logic signed [SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: design/cmb_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

// Configuration registers; delay, gain, damping and mix values are clamped as they are written
module cmb_cfg
	import cmb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  index,
	input  wire logic [CFG_DATA_W-1:0] data,
	output cmb_cfg_t                   cfg
);

	logic [ADDR_W-1:0]          delay_q;
	comb_mode_t                 mode_q;
	logic signed [SAMPLE_W-1:0] fb_q;
	logic [CFG_DATA_W-1:0]      damp_q;
	logic [CFG_DATA_W-1:0]      mix_q;
	logic [CFG_DATA_W-1:0]      level_q;

	logic [ADDR_W-1:0]          delay_clamped;
	logic signed [SAMPLE_W-1:0] fb_raw;
	logic signed [SAMPLE_W-1:0] fb_clamped;
	logic [CFG_DATA_W-1:0]      coef_clamped;

	// Clamp incoming data for the delay, gain, damping and mix registers
	always_comb begin
		delay_clamped = data[ADDR_W-1:0];
		if (delay_clamped < DELAY_MIN) begin
			delay_clamped = DELAY_MIN;
		end else if (delay_clamped > DELAY_MAX) begin
			delay_clamped = DELAY_MAX;
		end

		fb_raw     = $signed(data[SAMPLE_W-1:0]);
		fb_clamped = fb_raw;
		if (fb_raw > FB_LIMIT) begin
			fb_clamped = FB_LIMIT;
		end else if (fb_raw < -FB_LIMIT) begin
			fb_clamped = -FB_LIMIT;
		end

		coef_clamped = (data > Q_ONE) ? Q_ONE : data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= ADDR_W'(220);
			mode_q  <= MODE_FEEDFORWARD;
			fb_q    <= '0;
			damp_q  <= '0;
			mix_q   <= Q_ONE;
			level_q <= 16'd8192;
		end else if (wr_en) begin
			case (cfg_reg_t'(index))
				REG_DELAY_LENGTH: begin
					delay_q <= delay_clamped;
				end
				REG_COMB_MODE: begin
					mode_q <= comb_mode_t'(data[1:0]);
				end
				REG_FEEDBACK_GAIN: begin
					fb_q <= fb_clamped;
				end
				REG_DAMPING_COEF: begin
					damp_q <= coef_clamped;
				end
				REG_WET_MIX: begin
					mix_q <= coef_clamped;
				end
				REG_OUT_LEVEL: begin
					level_q <= data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.delay_len = delay_q;
	assign cfg.mode      = mode_q;
	assign cfg.fb_gain   = fb_q;
	assign cfg.damp      = damp_q;
	assign cfg.mix       = mix_q;
	assign cfg.level     = level_q;

endmodule

`default_nettype wire

// File: design/cmb_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Read-modify-write sequencer around the delay line, one shared multiplier
module cmb_core
	import cmb_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cmb_cfg_t                   cfg,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      sample_out
);

	core_state_t state_q, state_d;

	logic [ADDR_W-1:0]          wp_q;
	logic                       filled_q;
	logic                       rd_ok_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] delayed_q;
	logic signed [SAMPLE_W-1:0] lp_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [MUL_W-1:0]    wet_q;
	logic signed [MUL_W-1:0]    y_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;

	logic                       accept;
	logic                       ram_we;
	logic                       mul_en;
	logic                       out_load;
	logic [ADDR_W-1:0]          rd_addr;
	logic                       rd_ok;
	logic signed [SAMPLE_W-1:0] ram_rdata;
	logic signed [SAMPLE_W-1:0] delayed_now;
	logic signed [MUL_W-1:0]    mul_a;
	logic signed [MUL_W-1:0]    mul_b;
	logic signed [21:0]         prod_r15;
	logic signed [23:0]         x_plus;
	logic signed [23:0]         lp_sum;
	logic signed [MUL_W-1:0]    wet_d;
	logic signed [SAMPLE_W-1:0] wr_data;

	assign accept = in_valid && in_ready;

	// Read address trails the write pointer; entries never written read as zero
	assign rd_addr = wp_q - cfg.delay_len;
	assign rd_ok   = filled_q || (cfg.delay_len <= wp_q);

	cmb_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (wr_data),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign delayed_now = rd_ok_q ? ram_rdata : '0;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				state_d = (cfg.mode == MODE_DAMPED) ? ST_LP : ST_WB;
			end
			ST_LP: begin
				state_d = ST_FB2;
			end
			ST_FB2: begin
				state_d = ST_WB;
			end
			ST_WB: begin
				state_d = ST_MIX;
			end
			ST_MIX: begin
				state_d = ST_BLEND;
			end
			ST_BLEND: begin
				state_d = ST_LVL;
			end
			ST_LVL: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control outputs
	always_comb begin
		in_ready = 1'b0;
		ram_we   = 1'b0;
		mul_en   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_MUL1, ST_FB2, ST_MIX, ST_LVL: begin
				mul_en = 1'b1;
			end
			ST_WB: begin
				ram_we = 1'b1;
			end
			ST_OUT: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	// Multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL1: begin
				if (cfg.mode == MODE_DAMPED) begin
					mul_a = MUL_W'($signed({1'b0, cfg.damp}));
					mul_b = MUL_W'(delayed_now) - MUL_W'(lp_q);
				end else begin
					mul_a = MUL_W'(cfg.fb_gain);
					mul_b = MUL_W'(delayed_now);
				end
			end
			ST_FB2: begin
				mul_a = MUL_W'(cfg.fb_gain);
				mul_b = MUL_W'(lp_q);
			end
			ST_MIX: begin
				mul_a = MUL_W'($signed({1'b0, cfg.mix}));
				mul_b = wet_q - MUL_W'(x_q);
			end
			ST_LVL: begin
				mul_a = MUL_W'($signed({1'b0, cfg.level}));
				mul_b = y_q;
			end
			default: begin
			end
		endcase
	end

	// Post-multiply arithmetic
	always_comb begin
		prod_r15 = round_q15(prod_q);
		x_plus   = 24'(x_q) + 24'(prod_r15);
		lp_sum   = 24'(lp_q) + 24'(prod_r15);
		case (cfg.mode)
			MODE_FEEDFORWARD: begin
				wet_d   = x_plus[MUL_W-1:0];
				wr_data = x_q;
			end
			MODE_FEEDBACK, MODE_DAMPED: begin
				wet_d   = MUL_W'(delayed_q);
				wr_data = sat_sample(x_plus);
			end
			default: begin
				wet_d   = MUL_W'(delayed_q);
				wr_data = x_q;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			filled_q    <= 1'b0;
			lp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				wp_q <= wp_q + 1'b1;
				if (&wp_q) begin
					filled_q <= 1'b1;
				end
			end
			if (state_q == ST_LP) begin
				lp_q <= sat_sample(lp_sum);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= sample_in;
			rd_ok_q <= rd_ok;
		end
		if (state_q == ST_MUL1) begin
			delayed_q <= delayed_now;
		end
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_WB) begin
			wet_q <= wet_d;
		end
		if (state_q == ST_BLEND) begin
			y_q <= x_plus[MUL_W-1:0];
		end
		if (out_load) begin
			sample_out_q <= sat_sample(round_q13(prod_q));
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// An accepted item always starts with the delayed read
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MUL1))
		else $error("accepted item did not start its read");

	// Each write-back moves the write pointer by exactly one
	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (wp_q == $past(wp_q) + 1'b1))
		else $error("write pointer did not advance on write-back");

	// The lowpass update only runs in damped mode
	a_lp_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LP) |-> (cfg.mode == MODE_DAMPED))
		else $error("lowpass update outside damped mode");

	// A waiting result is never overwritten before it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(sample_out_q)))
		else $error("pending result was lost or changed");

endmodule

`default_nettype wire

// File: design/multi_mode_comb_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel     Signals                           Width   Direction
// input       in_valid / in_ready / sample_in   16 s    in
// output      out_valid / out_ready / sample_out 16 s   out
// config      cfg_wr_en / cfg_index / cfg_data  3, 16   in
//
// MUL1, LP and FB2 (damped only), WB, MIX, BLEND, LVL, then OUT registers the result
// when free; next item taken in the cycle after, one 18x18 multiplier time-shared.
// The delay line is a 4096-entry single-write, single-read memory; entries never
// written read as zero through the write-pointer fill flag, so no clearing pass.
// Reset clears control state only; the block accepts items right after reset.
// A finished result waits in the output register while the next item is taken.
module multi_mode_comb_filter
	import cmb_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      sample_out,
	input  wire logic                       cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

	cmb_cfg_t cfg;

	cmb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	cmb_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

endmodule

`default_nettype wire

// File: tb/sv/tb_multi_mode_comb_filter.sv
`timescale 1ns / 1ps

module tb_multi_mode_comb_filter;
	import cmb_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_WAIT  = 12;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_ITEMS = 50;
	localparam int MAX_REPORTS = 10;

	// Register indexes the block has no register for
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	// Clamp limits for the filter arithmetic
	localparam longint GAIN_CLAMP = 32440;
	localparam longint UNITY      = 32768;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       cfg_wr_en;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;

	// Filter state mirror
	logic signed [SAMPLE_W-1:0] echo_line [DELAY_DEPTH];
	logic [ADDR_W-1:0]          echo_ptr;
	logic signed [SAMPLE_W-1:0] lowpass_acc;

	// Register mirror
	logic [ADDR_W-1:0]          cur_delay;
	comb_mode_t                 cur_mode;
	logic signed [SAMPLE_W-1:0] cur_gain;
	logic [CFG_DATA_W-1:0]      cur_damp;
	logic [CFG_DATA_W-1:0]      cur_mix;
	logic [CFG_DATA_W-1:0]      cur_level;

	logic signed [SAMPLE_W-1:0] expected_out_q [$];

	int  mismatch_count;
	int  results_checked;
	int  items_sent;
	int  settings_used;
	int  cycle_count;
	int  stall_left;
	bit  gaps_on;

	multi_mode_comb_filter uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Q1.15 / Q3.13 product back to sample scale, ties go up
	function automatic longint qround(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] clip16(input longint v);
		if (v > 32767) begin
			return 16'sh7fff;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return v[SAMPLE_W-1:0];
	endfunction

	// One step of the comb filter: returns the output sample, updates the mirror
	function automatic logic signed [SAMPLE_W-1:0] comb_predict(
		input logic signed [SAMPLE_W-1:0] s);
		longint            x, fb, damp, mix, delayed, wet, wr, y;
		int                d;
		logic [ADDR_W-1:0] rd_addr;
		x = s;
		d = cur_delay;
		if (d < 1) begin
			d = 1;
		end
		if (d > DELAY_DEPTH - 2) begin
			d = DELAY_DEPTH - 2;
		end
		fb = cur_gain;
		if (fb > GAIN_CLAMP) begin
			fb = GAIN_CLAMP;
		end
		if (fb < -GAIN_CLAMP) begin
			fb = -GAIN_CLAMP;
		end
		damp = (longint'(cur_damp) > UNITY) ? UNITY : longint'(cur_damp);
		mix  = (longint'(cur_mix) > UNITY) ? UNITY : longint'(cur_mix);
		rd_addr = echo_ptr - ADDR_W'(d);
		delayed = echo_line[rd_addr];
		case (cur_mode)
			MODE_FEEDFORWARD: begin
				wet = x + qround(fb * delayed, 15);
				wr  = x;
			end
			MODE_FEEDBACK: begin
				wet = delayed;
				wr  = x + qround(fb * delayed, 15);
			end
			MODE_DAMPED: begin
				lowpass_acc = clip16(longint'(lowpass_acc) +
					qround(damp * (delayed - longint'(lowpass_acc)), 15));
				wet = delayed;
				wr  = x + qround(fb * longint'(lowpass_acc), 15);
			end
			default: begin
				wet = delayed;
				wr  = x;
			end
		endcase
		echo_line[echo_ptr] = clip16(wr);
		echo_ptr = echo_ptr + 1'b1;
		y = x + qround(mix * (wet - x), 15);
		return clip16(qround(y * longint'(cur_level), 13));
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (!gaps_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			return SAMPLE_W'($urandom());
		end else if (r < 8) begin
			return SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
		end
		return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
	endfunction

	// Send one item; the expected output is queued at acceptance
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		do @(posedge clk); while (!in_ready);
		expected_out_q.push_back(comb_predict(s));
		items_sent++;
	endtask

	// Register write, mirrored once it has taken effect
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_DELAY_LENGTH:  cur_delay = val[ADDR_W-1:0];
			REG_COMB_MODE:     cur_mode  = comb_mode_t'(val[1:0]);
			REG_FEEDBACK_GAIN: cur_gain  = val;
			REG_DAMPING_COEF:  cur_damp  = val;
			REG_WET_MIX:       cur_mix   = val;
			REG_OUT_LEVEL:     cur_level = val;
			default: ;
		endcase
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_all_regs(input logic [CFG_DATA_W-1:0] delay, input comb_mode_t mode,
		input logic [CFG_DATA_W-1:0] gain, input logic [CFG_DATA_W-1:0] damp,
		input logic [CFG_DATA_W-1:0] mix, input logic [CFG_DATA_W-1:0] level);
		write_reg(REG_DELAY_LENGTH, delay);
		write_reg(REG_COMB_MODE, CFG_DATA_W'(mode));
		write_reg(REG_FEEDBACK_GAIN, gain);
		write_reg(REG_DAMPING_COEF, damp);
		write_reg(REG_WET_MIX, mix);
		write_reg(REG_OUT_LEVEL, level);
		settings_used++;
	endtask

	// Stop sending and let every pending output come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_out_q.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Output side: random back-pressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready  <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	// Compare each output item with the oldest expectation
	always @(posedge clk) begin
		logic signed [SAMPLE_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_out_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("unexpected output item %0d", sample_out);
				end
			end else begin
				want = expected_out_q.pop_front();
				results_checked++;
				if (sample_out !== want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("sample_out mismatch at result %0d: expected %0d got %0d",
							results_checked, want, sample_out);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb: failure");
			$finish;
		end
	end

	// Reset values pass samples straight through
	task automatic test_defaults();
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(16'shffff);
	endtask

	// Zero delay, gain above the clamp, mix above one, full level: heavy saturation
	task automatic test_feedback_limits();
		wait_idle();
		set_all_regs(16'd0, MODE_FEEDBACK, 16'h7fff, 16'd0, 16'hffff, 16'hffff);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		send_sample(16'sh3039);
	endtask

	// Longest delay reads untouched entries; gain below the clamp, damping above one
	task automatic test_damped_limits();
		wait_idle();
		set_all_regs(16'd4095, MODE_DAMPED, 16'h8000, 16'hffff, 16'd16384, 16'd8192);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		send_sample(16'sh0000);
		send_sample(16'sh0001);
	endtask

	// Lowpass moves only in damped mode and keeps its value across other modes
	task automatic test_lowpass_hold();
		wait_idle();
		set_all_regs(16'd1, MODE_DAMPED, 16'd32767, 16'd20000, 16'd32768, 16'd8192);
		send_sample(16'sh7fff);
		send_sample(16'sh6000);
		send_sample(16'sh8000);
		wait_idle();
		write_reg(REG_COMB_MODE, CFG_DATA_W'(MODE_FEEDFORWARD));
		send_sample(16'sh4000);
		send_sample(16'shc000);
		wait_idle();
		write_reg(REG_COMB_MODE, CFG_DATA_W'(MODE_DAMPED));
		write_reg(REG_DELAY_LENGTH, 16'd4094);
		send_sample(16'sh1234);
		send_sample(16'shedcb);
	endtask

	// Mode 3: pure delay line
	task automatic test_plain_delay();
		wait_idle();
		set_all_regs(16'd2, MODE_PLAIN_DELAY, 16'd12000, 16'd0, 16'd32768, 16'd8192);
		send_sample(16'sh5555);
		send_sample(16'shaaaa);
		send_sample(16'sh0100);
		send_sample(16'shff00);
	endtask

	// Writes to indexes with no register change nothing; zero level mutes
	task automatic test_spare_index();
		wait_idle();
		write_reg(REG_SPARE_6, 16'hffff);
		write_reg(REG_SPARE_7, 16'hffff);
		send_sample(16'sh7fff);
		send_sample(16'sh8001);
		wait_idle();
		write_reg(REG_OUT_LEVEL, 16'd0);
		send_sample(16'sh7fff);
	endtask

	// Random settings per phase with random sample streams
	task automatic test_random_traffic();
		logic [CFG_DATA_W-1:0] delay, gain, damp, mix, level;
		int r;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			r = $urandom_range(0, 99);
			if (ph == RANDOM_PHASES - 1) begin
				// reach back into samples written earlier in the run
				delay = 16'($urandom_range(100, 380));
			end else if (r < 75) begin
				delay = 16'($urandom_range(1, 40));
			end else begin
				delay = 16'($urandom_range(0, 4095));
			end
			r = $urandom_range(0, 99);
			if (r < 85) begin
				gain = 16'($urandom());
			end else begin
				case ($urandom_range(0, 3))
					0: gain = 16'h7fff;
					1: gain = 16'h8000;
					2: gain = 16'd32440;
					default: gain = -16'sd32440;
				endcase
			end
			damp  = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768));
			mix   = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768));
			level = ($urandom_range(0, 9) == 0) ? 16'($urandom()) :
				16'($urandom_range(2048, 16384));
			set_all_regs(delay, comb_mode_t'(ph % 4), gain, damp, mix, level);
			gaps_on = !(ph == 3 || ph == 7);
			repeat (PHASE_ITEMS) send_sample(rand_sample());
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		sample_in      = '0;
		out_ready      = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		mismatch_count = 0;
		results_checked = 0;
		items_sent     = 0;
		settings_used  = 1;
		cycle_count    = 0;
		stall_left     = 0;
		gaps_on        = 1'b1;

		// mirror starts from the reset state
		for (int i = 0; i < DELAY_DEPTH; i++) begin
			echo_line[i] = '0;
		end
		echo_ptr    = '0;
		lowpass_acc = '0;
		cur_delay   = 12'd220;
		cur_mode    = MODE_FEEDFORWARD;
		cur_gain    = '0;
		cur_damp    = '0;
		cur_mix     = 16'd32768;
		cur_level   = 16'd8192;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_feedback_limits();
		test_damped_limits();
		test_lowpass_hold();
		test_plain_delay();
		test_spare_index();
		test_random_traffic();
		wait_idle();

		if (expected_out_q.size() != 0) begin
			$display("%0d expected outputs never arrived", expected_out_q.size());
			mismatch_count += expected_out_q.size();
		end
		$display("%0d samples sent under %0d register settings, all four comb modes",
			items_sent, settings_used);
		$display("%0d outputs checked, %0d mismatches", results_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: multi_mode_comb_filter.f
design/cmb_pkg.sv
design/cmb_ram.sv
design/cmb_cfg.sv
design/cmb_core.sv
design/multi_mode_comb_filter.sv
tb/sv/tb_multi_mode_comb_filter.sv
